// ===== hdl/td_pkg.sv =====
// Shared types and constants for the tracking differentiator.
`default_nettype none

package td_pkg;

    // Datapath widths of the shared iterative unit
    localparam int ACC_W  = 104;  // accumulator / remainder / source shift register
    localparam int OPND_W = 53;   // multiplicand or divisor
    localparam int ROOT_W = 51;   // square root or quotient
    localparam int CNT_W  = 6;    // step counter

    // Widths of the internal fhan terms (32 fraction bits)
    localparam int AW = 56;       // signed x1, y, a0, a2, a
    localparam int DW = 48;       // unsigned d

    localparam int CFG_IDX_W = 1;
    localparam logic [24:0] H_ONE = 25'h100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_FACTOR = 1'b0,
        REG_STEP_SIZE    = 1'b1
    } td_reg_idx_t;

    typedef enum logic [1:0] {
        TD_OP_MUL,
        TD_OP_DIV,
        TD_OP_SQRT
    } td_op_t;

    typedef struct packed {
        td_op_t              op;
        logic [ACC_W-1:0]    acc_init;
        logic [ACC_W-1:0]    src;       // multiplier / numerator / radicand, MSB first
        logic [OPND_W-1:0]   opnd;
        logic [CNT_W-1:0]    count;
    } td_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [ACC_W-1:0]    acc;
        logic [ROOT_W-1:0]   res;
    } td_rsp_t;

    typedef struct packed {
        logic signed [31:0]  target;
        logic                restart;
    } td_in_t;

    typedef struct packed {
        logic signed [31:0]  position;
        logic signed [31:0]  rate;
    } td_out_t;

endpackage

`default_nettype wire

// ===== hdl/td_iter_unit.sv =====
// Shared bit-serial unit: shift-add multiply, restoring divide and square root.
`default_nettype none

module td_iter_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire td_pkg::td_req_t req,
    output td_pkg::td_rsp_t      rsp
);
    import td_pkg::*;

    td_op_t              op_reg;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    src_reg, src_next;
    logic [OPND_W-1:0]   opnd_reg;
    logic [ROOT_W-1:0]   res_reg, res_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ACC_W-1:0]    add_x, add_y;
    logic [ACC_W:0]      add_sum;
    logic                add_sub;
    logic                ge;

    // One adder serves every mode; for subtraction the carry out means x >= y
    always_comb begin
        add_x    = {acc_reg[ACC_W-2:0], 1'b0};
        add_y    = '0;
        add_sub  = 1'b0;
        acc_next = acc_reg;
        src_next = src_reg;
        res_next = res_reg;
        case (op_reg)
            TD_OP_MUL: begin
                add_x   = {acc_reg[ACC_W-2:0], 1'b0};
                add_y   = src_reg[ACC_W-1] ? ACC_W'(opnd_reg) : '0;
                add_sub = 1'b0;
            end
            TD_OP_DIV: begin
                add_x   = {acc_reg[ACC_W-2:0], src_reg[ACC_W-1]};
                add_y   = ACC_W'(opnd_reg);
                add_sub = 1'b1;
            end
            TD_OP_SQRT: begin
                add_x   = {acc_reg[ACC_W-3:0], src_reg[ACC_W-1:ACC_W-2]};
                add_y   = ACC_W'({res_reg, 2'b01});
                add_sub = 1'b1;
            end
            default: begin
                add_x   = acc_reg;
                add_y   = '0;
                add_sub = 1'b0;
            end
        endcase

        add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                  + (ACC_W+1)'(add_sub);
        ge      = add_sum[ACC_W];

        case (op_reg)
            TD_OP_MUL: begin
                acc_next = add_sum[ACC_W-1:0];
                src_next = {src_reg[ACC_W-2:0], 1'b0};
            end
            TD_OP_DIV: begin
                acc_next = ge ? add_sum[ACC_W-1:0] : add_x;
                src_next = {src_reg[ACC_W-2:0], 1'b0};
                res_next = {res_reg[ROOT_W-2:0], ge};
            end
            TD_OP_SQRT: begin
                acc_next = ge ? add_sum[ACC_W-1:0] : add_x;
                src_next = {src_reg[ACC_W-3:0], 2'b00};
                res_next = {res_reg[ROOT_W-2:0], ge};
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                op_reg   <= req.op;
                acc_reg  <= req.acc_init;
                src_reg  <= req.src;
                opnd_reg <= req.opnd;
                res_reg  <= '0;
                cnt_reg  <= req.count;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                src_reg <= src_next;
                res_reg <= res_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

// ===== hdl/tracking_differentiator.sv =====
// Top level of the fhan tracking differentiator.
`default_nettype none

// Tracks a signed Q16.16 target with a position and a rate, one item per tick.
// Every multiply, the square root and the divide run one bit per cycle through
// a single shared adder: five multiply passes of 25 to 48 steps and a 51-step
// root, plus a sixth multiply and a 48-step divide when fhan needs the divide.
// A restart item skips the arithmetic and goes straight to the output step.
// s_ready is high only while the sequencer is idle; a finished result waits in
// the output register while the next item runs.
// speed_factor (index 0) and step_size (index 1) should be written while idle.
module tracking_differentiator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire td_pkg::td_in_t                 s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output td_pkg::td_out_t                     m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [td_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                    cfg_wdata
);
    import td_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_H2, ST_D, ST_PV, ST_Y, ST_RAD, ST_RADW, ST_SQ,
        ST_A, ST_FH, ST_NUM, ST_DIV, ST_FIN, ST_FINW, ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [31:0]            speed_reg;
    logic [24:0]            step_reg;
    logic signed [31:0]     pos_reg, rate_reg;
    logic signed [31:0]     target_reg;
    logic [DW-1:0]          d_reg;
    logic signed [AW-1:0]   x1_reg, a0_reg, y_reg, a2_reg, a_reg;
    logic signed [33:0]     pinc_reg;
    logic [1:0]             wy_reg, wa_reg;
    logic [47:0]            m_reg;
    logic                   fneg_reg;
    logic signed [31:0]     po_reg, ro_reg;
    td_req_t                req_reg;
    logic                   start_reg;
    logic                   m_valid_reg;
    td_out_t                m_data_reg;
    td_rsp_t                rsp;

    td_iter_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .req     (req_reg),
        .rsp     (rsp)
    );

    // fsg in halves: 2 inside, 1 on the edge, 0 outside or when d is zero
    function automatic logic [1:0] fsg(input logic [AW-1:0] m, input logic [DW-1:0] d);
        logic [1:0] w;
        if (d == '0)
            w = 2'd0;
        else if (m < AW'(d))
            w = 2'd2;
        else if (m == AW'(d))
            w = 2'd1;
        else
            w = 2'd0;
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] s;
        if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111))
            s = v[31:0];
        else if (v[35])
            s = 32'sh8000_0000;
        else
            s = 32'sh7FFF_FFFF;
        return s;
    endfunction

    logic [24:0]            h_clamp;
    logic                   v_neg;
    logic [31:0]            v_mag;
    logic [55:0]            pv;
    logic signed [AW-1:0]   a0_val, x1_val, y_mag_s;
    logic signed [33:0]     pinc_val;
    logic [AW-1:0]          y_mag, a_mag;
    logic [OPND_W-1:0]      rad_a;
    logic [ROOT_W-1:0]      a1;
    logic [ROOT_W-1:0]      a1_diff;
    logic [ROOT_W-2:0]      half;
    logic signed [AW-1:0]   a2_val, a0y, a_val;
    logic [1:0]             wa;
    logic [48:0]            m_sum;
    logic [72:0]            prod;
    logic signed [34:0]     inc_val;
    logic signed [35:0]     rate_sum, pos_sum;

    always_comb begin
        h_clamp = (step_reg > H_ONE) ? H_ONE : step_reg;
        v_neg   = rate_reg[31];
        v_mag   = v_neg ? (32'd0 - rate_reg) : rate_reg;

        // floor(v*h / 2^8) and floor(v*h / 2^24) from one magnitude product
        pv       = rsp.acc[55:0];
        a0_val   = v_neg ? -(AW'(pv[55:8]) + AW'(pv[7:0] != '0)) : AW'(pv[55:8]);
        pinc_val = v_neg ? -(34'(pv[55:24]) + 34'(pv[23:0] != '0)) : 34'(pv[55:24]);
        x1_val   = (AW'(pos_reg) - AW'(target_reg)) <<< 16;

        y_mag_s = y_reg[AW-1] ? -y_reg : y_reg;
        y_mag   = y_mag_s;
        rad_a   = OPND_W'(d_reg) + {y_mag[49:0], 3'b000};

        a1      = rsp.res;
        a1_diff = a1 - ROOT_W'(d_reg);
        half    = a1_diff[ROOT_W-1:1];
        if (y_reg == '0)
            a2_val = a0_reg;
        else if (y_reg[AW-1])
            a2_val = a0_reg - AW'(half);
        else
            a2_val = a0_reg + AW'(half);

        a0y = a0_reg + y_reg;
        case (wy_reg)
            2'd2:    a_val = a0y;
            2'd1:    a_val = (a0y + a2_reg) >>> 1;
            default: a_val = a2_reg;
        endcase

        a_mag = a_reg[AW-1] ? AW'(-a_reg) : AW'(a_reg);
        wa    = fsg(a_mag, d_reg);

        m_sum = 49'(rsp.res[47:0]) + 49'({speed_reg, 16'h0000});

        // floor(fhan*h / 2^40) with fhan's sign applied to the magnitude product
        prod    = rsp.acc[72:0];
        inc_val = fneg_reg ? -(35'(prod[72:40]) + 35'(prod[39:0] != '0))
                           : 35'(prod[72:40]);
        rate_sum = 36'(rate_reg) + 36'(inc_val);
        pos_sum  = 36'(pos_reg) + 36'(pinc_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            speed_reg   <= 32'd655360;
            step_reg    <= 25'd167772;
            pos_reg     <= '0;
            rate_reg    <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_ready)
                m_valid_reg <= 1'b0;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SPEED_FACTOR: speed_reg <= cfg_wdata;
                    REG_STEP_SIZE:    step_reg  <= cfg_wdata[24:0];
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        target_reg <= s_data.target;
                        if (s_data.restart) begin
                            po_reg    <= s_data.target;
                            ro_reg    <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            req_reg   <= '{TD_OP_MUL, '0, {h_clamp, 79'b0},
                                           OPND_W'(h_clamp), CNT_W'(25)};
                            start_reg <= 1'b1;
                            state_reg <= ST_H2;
                        end
                    end
                end
                ST_H2: begin
                    if (rsp.done) begin
                        // r * (h*h >> 16)
                        req_reg   <= '{TD_OP_MUL, '0, {speed_reg, 72'b0},
                                       OPND_W'(rsp.acc[48:16]), CNT_W'(32)};
                        start_reg <= 1'b1;
                        state_reg <= ST_D;
                    end
                end
                ST_D: begin
                    if (rsp.done) begin
                        d_reg     <= rsp.acc[63:16];
                        req_reg   <= '{TD_OP_MUL, '0, {h_clamp, 79'b0},
                                       OPND_W'(v_mag), CNT_W'(25)};
                        start_reg <= 1'b1;
                        state_reg <= ST_PV;
                    end
                end
                ST_PV: begin
                    if (rsp.done) begin
                        a0_reg    <= a0_val;
                        pinc_reg  <= pinc_val;
                        x1_reg    <= x1_val;
                        state_reg <= ST_Y;
                    end
                end
                ST_Y: begin
                    y_reg     <= x1_reg + a0_reg;
                    state_reg <= ST_RAD;
                end
                ST_RAD: begin
                    wy_reg    <= fsg(y_mag, d_reg);
                    req_reg   <= '{TD_OP_MUL, '0, {d_reg, 56'b0}, rad_a, CNT_W'(48)};
                    start_reg <= 1'b1;
                    state_reg <= ST_RADW;
                end
                ST_RADW: begin
                    if (rsp.done) begin
                        req_reg   <= '{TD_OP_SQRT, '0, {rsp.acc[101:0], 2'b00},
                                       '0, CNT_W'(51)};
                        start_reg <= 1'b1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (rsp.done) begin
                        a2_reg    <= a2_val;
                        state_reg <= ST_A;
                    end
                end
                ST_A: begin
                    a_reg     <= a_val;
                    state_reg <= ST_FH;
                end
                ST_FH: begin
                    fneg_reg <= !a_reg[AW-1] && (a_reg != '0);
                    wa_reg   <= wa;
                    if (a_reg == '0) begin
                        m_reg     <= '0;
                        state_reg <= ST_FIN;
                    end else if (wa == 2'd0) begin
                        m_reg     <= {speed_reg, 16'h0000};
                        state_reg <= ST_FIN;
                    end else begin
                        req_reg   <= '{TD_OP_MUL, '0, {speed_reg, 72'b0},
                                       OPND_W'(a_mag[47:0]), CNT_W'(32)};
                        start_reg <= 1'b1;
                        state_reg <= ST_NUM;
                    end
                end
                ST_NUM: begin
                    if (rsp.done) begin
                        // (r*|a| << 16) / d; the top 48 bits start below d
                        req_reg   <= '{TD_OP_DIV, ACC_W'(rsp.acc[79:32]),
                                       {rsp.acc[31:0], 72'b0}, OPND_W'(d_reg),
                                       CNT_W'(48)};
                        start_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rsp.done) begin
                        m_reg     <= (wa_reg == 2'd2) ? rsp.res[47:0] : m_sum[48:1];
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    req_reg   <= '{TD_OP_MUL, '0, {h_clamp, 79'b0},
                                   OPND_W'(m_reg), CNT_W'(25)};
                    start_reg <= 1'b1;
                    state_reg <= ST_FINW;
                end
                ST_FINW: begin
                    if (rsp.done) begin
                        po_reg    <= sat32(pos_sum);
                        ro_reg    <= sat32(rate_sum);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.position <= po_reg;
                        m_data_reg.rate     <= ro_reg;
                        m_valid_reg         <= 1'b1;
                        pos_reg             <= po_reg;
                        rate_reg            <= ro_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_ready_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !rsp.busy)
        else $error("input ready while the shared unit is busy");

    a_restart_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.restart) |=> (state_reg == ST_OUT))
        else $error("restart item did not go straight to output");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg != ST_IDLE && state_reg != ST_OUT))
        else $error("unit finished while no step was waiting for it");

endmodule

`default_nettype wire

// ===== test/tracking_differentiator_checker.sv =====
// Checker for the tracking differentiator: predicts each result and compares it.
`timescale 1ns / 1ps

module tracking_differentiator_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire td_pkg::td_in_t               s_data,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire td_pkg::td_out_t              m_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic [td_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                  cfg_wdata,
    output int                                fail_count,
    output int                                outstanding,
    output int                                results_seen
);
    import td_pkg::*;

    logic signed [31:0] pos_st;
    logic signed [31:0] rate_st;
    logic [31:0]        speed_st;
    logic [24:0]        step_st;
    td_out_t            expected_q[$];

    assign outstanding = expected_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -128'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // halves of fsg: 2 inside the band, 1 on its edge, 0 outside or with zero width
    function automatic int fsg_halves(input logic [127:0] mag, input logic [127:0] width);
        if (width == 0)
            return 0;
        if (mag < width)
            return 2;
        return (mag == width) ? 1 : 0;
    endfunction

    function automatic logic [127:0] floor_root(input logic [127:0] n);
        logic [127:0] root;
        logic [127:0] c;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
            c = root | (128'd1 << b);
            if (c * c <= n)
                root = c;
        end
        return root;
    endfunction

    // advance the tracked pair by one item and return the new pair
    function automatic td_out_t track_step(input td_in_t item);
        logic signed [127:0] p, v, t, x1, a0, y, a2, a, fh, half;
        logic [127:0]        h, r, h2, d, ay, a1, ma, q;
        logic [63:0]         q64, m64;
        int                  wy, wa;
        td_out_t             res;
        p = pos_st;
        v = rate_st;
        t = item.target;
        r = speed_st;
        h = (step_st > H_ONE) ? H_ONE : step_st;
        if (item.restart) begin
            pos_st = item.target;
            rate_st = 0;
        end else begin
            x1 = (p - t) * 65536;
            h2 = (h * h) >> 16;
            d = (r * h2) >> 16;
            a0 = (v * $signed(h)) >>> 8;
            y = x1 + a0;
            ay = (y < 0) ? -y : y;
            a1 = floor_root(d * (d + 8 * ay));
            half = $signed((a1 - d) >> 1);
            a2 = (y > 0) ? a0 + half : ((y < 0) ? a0 - half : a0);
            wy = fsg_halves(ay, d);
            if (wy == 2)
                a = a0 + y;
            else if (wy == 0)
                a = a2;
            else
                a = (a0 + y + a2) >>> 1;
            fh = 0;
            if (a != 0) begin
                ma = (a < 0) ? -a : a;
                wa = fsg_halves(ma, d);
                q = (wa > 0) ? ((r * ma) << 16) / d : 0;
                q64 = q[63:0];
                m64 = (q64 * 64'(wa) + (r[63:0] << 16) * 64'(2 - wa)) >> 1;
                fh = {64'b0, m64};
                if (a > 0)
                    fh = -fh;
            end
            pos_st = clamp32(p + ((v * $signed(h)) >>> 24));
            rate_st = clamp32(v + ((fh * $signed(h)) >>> 40));
        end
        res.position = pos_st;
        res.rate = rate_st;
        return res;
    endfunction

    always @(posedge aclk) begin
        td_out_t want;
        if (!aresetn) begin
            pos_st <= 0;
            rate_st <= 0;
            speed_st <= 32'd655360;
            step_st <= 25'd167772;
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (td_reg_idx_t'(cfg_index))
                    REG_SPEED_FACTOR: speed_st = cfg_wdata;
                    REG_STEP_SIZE:    step_st = cfg_wdata[24:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.push_back(track_step(s_data));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t result with nothing expected: %h", $realtime, m_data);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.position !== want.position)
                        report("position", m_data.position, want.position);
                    if (m_data.rate !== want.rate)
                        report("rate", m_data.rate, want.rate);
                end
            end
        end
    end

endmodule

// ===== test/tracking_differentiator_test.sv =====
// Top of the tracking differentiator testbench: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tracking_differentiator_test;
    import td_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 800;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    td_in_t               s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    td_out_t              m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int results_seen;
    int items_sent = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit quiet = 1'b0;

    always #5 aclk = ~aclk;

    tracking_differentiator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    tracking_differentiator_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left = pick_gap();
            m_ready <= (hold_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic signed [31:0] target, input logic restart);
        int gap;
        s_data.target <= target;
        s_data.restart <= restart;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input td_reg_idx_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] speed, input logic [31:0] step);
        drain();
        write_reg(REG_SPEED_FACTOR, speed);
        write_reg(REG_STEP_SIZE, step);
        settings_used++;
    endtask

    function automatic logic signed [31:0] random_target();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        if (roll < 8)
            return $urandom;
        return (roll == 8) ? 32'sh7FFF_FFFF - $urandom_range(0, 15)
                           : 32'sh8000_0000 + $urandom_range(0, 15);
    endfunction

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_target(), $urandom_range(0, 15) == 0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values first, extremes of the target
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0, 1'b1);
        send_item(32'sh0, 1'b0);

        // unit step, r = 5.0: error equal to d, zero a, and large swings
        set_regs(32'h0005_0000, 32'h100_0000);
        send_item(32'sh0, 1'b1);
        send_item(-32'sh0005_0000, 1'b0);
        send_item(32'sh0, 1'b1);
        send_item(32'sh0005_0000, 1'b0);
        send_item(32'sh0, 1'b1);
        send_item(32'sh0, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);

        // zero step and zero speed give d = 0
        set_regs(32'h0005_0000, 32'h0);
        send_item(32'sh0001_0000, 1'b0);
        set_regs(32'h0, 32'h1FF_FFFF);
        send_item(32'sh1234_5678, 1'b1);
        send_item(-32'sh0001_0000, 1'b0);
        send_item(32'sh0001_0000, 1'b0);

        // random phases over several settings
        set_regs(32'd655360, 32'd167772);
        random_items(250);
        set_regs(32'hFFFF_FFFF, 32'h100_0000);
        random_items(200);
        set_regs(32'h0000_0001, 32'h1FF_FFFF);
        random_items(150);
        set_regs($urandom, $urandom_range(0, 32'h1FF_FFFF));
        quiet = 1'b1;
        random_items(150);
        quiet = 1'b0;
        set_regs($urandom_range(1, 32'h0100_0000), $urandom_range(1000, 400000));
        quiet = 1'b1;
        hold_req++;
        random_items(60);
        quiet = 1'b0;
        random_items(200);
        set_regs(32'h0, 32'h0);
        random_items(100);
        set_regs($urandom, $urandom_range(0, 32'h100_0000));
        random_items(250);
        set_regs($urandom_range(0, 32'h0064_0000), $urandom_range(0, 32'h0010_0000));
        random_items(200);

        drain();
        repeat (400) @(posedge aclk);
        $display("Ran %0d items (%0d results checked) over %0d register settings,",
                 items_sent, results_seen, settings_used);
        $display("including restarts, saturation, zero d, edge-of-band errors and stalls.");
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
